// File: rtl/mpde_pkg.sv
package mpde_pkg;

    // field widths of the channels and the configuration port
    localparam int BASE_W   = 31;
    localparam int DIGIT_W  = 4;
    localparam int RESULT_W = 16;
    localparam int CFG_W    = 16;

    // default modulus width and reset modulus
    localparam int              MOD_WIDTH_DEFAULT = 16;
    localparam logic [CFG_W-1:0] MODULUS_RESET    = 16'd1337;

    // the running result is raised to this power on every digit
    localparam logic [DIGIT_W-1:0] POW_TEN = 4'd10;

    // dividend bits consumed by the reducer per cycle
    localparam int RED_BITS = 4;

    // first multiplier operand
    typedef enum logic [0:0] {
        OPA_ACC,
        OPA_R10
    } opa_sel_t;

    // second multiplier operand
    typedef enum logic [1:0] {
        OPB_ACC,
        OPB_RUN,
        OPB_BASE
    } opb_sel_t;

    // register that takes the reduced product
    typedef enum logic [1:0] {
        DEST_BASE,
        DEST_ACC,
        DEST_RUN
    } dest_t;

    // controller to datapath
    typedef struct packed {
        logic     load_item;
        logic     acc_init;
        logic     save_r10;
        logic     mm_start;
        logic     mm_raw;
        opa_sel_t opa_sel;
        opb_sel_t opb_sel;
        dest_t    dest;
        logic     out_load;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic               first;
        logic               last;
        logic [DIGIT_W-1:0] digit;
        logic               mm_done;
        logic               out_full;
    } ctrl_status_t;

endpackage

// File: rtl/mpde_in_if.sv
interface mpde_in_if;

    logic                         valid;
    logic                         ready;
    logic [mpde_pkg::BASE_W-1:0]  base_value;
    logic [mpde_pkg::DIGIT_W-1:0] exp_digit;
    logic                         first_digit;
    logic                         last_digit;

    modport source (
        output valid,
        output base_value,
        output exp_digit,
        output first_digit,
        output last_digit,
        input  ready
    );

    modport sink (
        input  valid,
        input  base_value,
        input  exp_digit,
        input  first_digit,
        input  last_digit,
        output ready
    );

endinterface

// File: rtl/mpde_out_if.sv
interface mpde_out_if;

    logic                          valid;
    logic                          ready;
    logic [mpde_pkg::RESULT_W-1:0] power_result;

    modport source (
        output valid,
        output power_result,
        input  ready
    );

    modport sink (
        input  valid,
        input  power_result,
        output ready
    );

endinterface

// File: rtl/mpde_modmul.sv
module mpde_modmul #(
    parameter int W = mpde_pkg::MOD_WIDTH_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic                        raw,
    input  logic [W-1:0]                op_a,
    input  logic [W-1:0]                op_b,
    input  logic [mpde_pkg::BASE_W-1:0] raw_value,
    input  logic [W-1:0]                modulus,
    output logic                        done,
    output logic [W-1:0]                result
);

    localparam int RAW_W = (2 * W > mpde_pkg::BASE_W) ? 2 * W : mpde_pkg::BASE_W;
    localparam int STEPS = (RAW_W + mpde_pkg::RED_BITS - 1) / mpde_pkg::RED_BITS;
    localparam int DW    = STEPS * mpde_pkg::RED_BITS;
    localparam int CW    = $clog2(STEPS);

    logic          run_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [DW-1:0] div_reg;
    logic [W-1:0]  rem_reg;
    logic [W-1:0]  result_reg;

    logic [2*W-1:0] product;
    logic [W:0]     rem_step;
    logic [W:0]     shifted;
    logic [W-1:0]   rem_next;
    logic           mod_zero;
    logic           last_step;

    // one multiply per operation, registered into the dividend
    assign product   = (2 * W)'(op_a) * (2 * W)'(op_b);
    assign mod_zero  = (modulus == '0);
    assign last_step = (cnt_reg == CW'(STEPS - 1));

    // restoring remainder, a few dividend bits per cycle
    always_comb
    begin
        rem_step = {1'b0, rem_reg};
        shifted  = '0;
        for (int i = 0; i < mpde_pkg::RED_BITS; i++)
        begin
            shifted = {rem_step[W-1:0], div_reg[DW-1-i]};
            if (shifted >= {1'b0, modulus})
            begin
                rem_step = shifted - {1'b0, modulus};
            end
            else
            begin
                rem_step = shifted;
            end
        end
        rem_next = rem_step[W-1:0];
    end

    // iteration control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                if (mod_zero || last_step)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg + CW'(1);
                end
            end
        end
    end

    // dividend, partial remainder and result
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            div_reg <= raw ? DW'(raw_value) : DW'(product);
            rem_reg <= '0;
        end
        else if (run_reg)
        begin
            div_reg    <= div_reg << mpde_pkg::RED_BITS;
            rem_reg    <= rem_next;
            // zero modulus wraps to the low bits instead of dividing
            result_reg <= mod_zero ? div_reg[W-1:0] : rem_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// File: rtl/mpde_datapath.sv
module mpde_datapath #(
    parameter int W = mpde_pkg::MOD_WIDTH_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [mpde_pkg::BASE_W-1:0]   base_value,
    input  logic [mpde_pkg::DIGIT_W-1:0]  exp_digit,
    input  logic                          first_digit,
    input  logic                          last_digit,
    input  logic                          cfg_we,
    input  logic [mpde_pkg::CFG_W-1:0]    cfg_wdata,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic [mpde_pkg::RESULT_W-1:0] power_result,
    input  mpde_pkg::ctrl_cmd_t           cmd,
    output mpde_pkg::ctrl_status_t        status
);

    logic [W-1:0]                   modulus_reg;
    logic [W-1:0]                   running_reg;
    logic [W-1:0]                   base_reg;
    logic [W-1:0]                   acc_reg;
    logic [W-1:0]                   r10_reg;
    logic [mpde_pkg::BASE_W-1:0]    base_in_reg;
    logic [mpde_pkg::DIGIT_W-1:0]   digit_reg;
    logic                           first_reg;
    logic                           last_reg;
    logic                           out_valid_reg;
    logic [mpde_pkg::RESULT_W-1:0]  out_data_reg;

    logic [W-1:0] op_a;
    logic [W-1:0] op_b;
    logic         mm_done;
    logic [W-1:0] mm_result;

    // operand selection
    always_comb
    begin
        unique case (cmd.opa_sel)
            mpde_pkg::OPA_R10: op_a = r10_reg;
            default:           op_a = acc_reg;
        endcase
        unique case (cmd.opb_sel)
            mpde_pkg::OPB_RUN:  op_b = running_reg;
            mpde_pkg::OPB_BASE: op_b = base_reg;
            default:            op_b = acc_reg;
        endcase
    end

    // shared modular multiplier
    mpde_modmul #(
        .W (W)
    ) u_modmul (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.mm_start),
        .raw       (cmd.mm_raw),
        .op_a      (op_a),
        .op_b      (op_b),
        .raw_value (base_in_reg),
        .modulus   (modulus_reg),
        .done      (mm_done),
        .result    (mm_result)
    );

    // modulus, running result, reduced base and output valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg   <= W'(mpde_pkg::MODULUS_RESET);
            running_reg   <= W'(1);
            base_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                modulus_reg <= W'(cfg_wdata);
            end
            if (cmd.load_item && first_digit)
            begin
                running_reg <= W'(1);
            end
            else if (mm_done && cmd.dest == mpde_pkg::DEST_RUN)
            begin
                running_reg <= mm_result;
            end
            if (mm_done && cmd.dest == mpde_pkg::DEST_BASE)
            begin
                base_reg <= mm_result;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // word latch, accumulator, saved tenth power and output word
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            base_in_reg <= base_value;
            digit_reg   <= exp_digit;
            first_reg   <= first_digit;
            last_reg    <= last_digit;
        end
        if (cmd.acc_init || cmd.save_r10)
        begin
            acc_reg <= W'(1);
        end
        else if (mm_done && cmd.dest == mpde_pkg::DEST_ACC)
        begin
            acc_reg <= mm_result;
        end
        if (cmd.save_r10)
        begin
            r10_reg <= acc_reg;
        end
        if (cmd.out_load)
        begin
            out_data_reg <= mpde_pkg::RESULT_W'(running_reg);
        end
    end

    assign status.first    = first_reg;
    assign status.last     = last_reg;
    assign status.digit    = digit_reg;
    assign status.mm_done  = mm_done;
    assign status.out_full = out_valid_reg;

    assign out_valid    = out_valid_reg;
    assign power_result = out_data_reg;

endmodule

// File: rtl/mpde_ctrl.sv
module mpde_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    output mpde_pkg::ctrl_cmd_t    cmd,
    input  mpde_pkg::ctrl_status_t status
);

    localparam int BW = $clog2(mpde_pkg::DIGIT_W);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_BASE,
        S_SQUARE,
        S_MULX,
        S_SAVE,
        S_FINAL,
        S_EMIT
    } state_t;

    state_t        state_reg;
    logic          pass_reg;
    logic [BW-1:0] bit_reg;
    logic          issued_reg;

    logic [mpde_pkg::DIGIT_W-1:0] exp_bits;
    logic                         cur_bit;
    logic                         bits_done;

    // pass 0 raises the running result to ten, pass 1 the base to the digit
    assign exp_bits  = pass_reg ? status.digit : mpde_pkg::POW_TEN;
    assign cur_bit   = exp_bits[bit_reg];
    assign bits_done = (bit_reg == '0);
    assign in_ready  = (state_reg == S_IDLE);

    // command decode
    always_comb
    begin
        cmd           = '0;
        cmd.opa_sel   = mpde_pkg::OPA_ACC;
        cmd.opb_sel   = mpde_pkg::OPB_ACC;
        cmd.dest      = mpde_pkg::DEST_ACC;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.load_item = in_valid;
            end
            S_LOAD:
            begin
                cmd.acc_init = 1'b1;
            end
            S_BASE:
            begin
                cmd.mm_start = !issued_reg;
                cmd.mm_raw   = 1'b1;
                cmd.dest     = mpde_pkg::DEST_BASE;
            end
            S_SQUARE:
            begin
                cmd.mm_start = !issued_reg;
            end
            S_MULX:
            begin
                cmd.mm_start = !issued_reg;
                cmd.opb_sel  = pass_reg ? mpde_pkg::OPB_BASE : mpde_pkg::OPB_RUN;
            end
            S_SAVE:
            begin
                cmd.save_r10 = 1'b1;
            end
            S_FINAL:
            begin
                cmd.mm_start = !issued_reg;
                cmd.opa_sel  = mpde_pkg::OPA_R10;
                cmd.dest     = mpde_pkg::DEST_RUN;
            end
            S_EMIT:
            begin
                cmd.out_load = !status.out_full;
            end
            default:
            begin
                cmd.load_item = 1'b0;
            end
        endcase
    end

    // state, pass, exponent bit and issue flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            pass_reg   <= 1'b0;
            bit_reg    <= '0;
            issued_reg <= 1'b0;
        end
        else
        begin
            if (cmd.mm_start)
            begin
                issued_reg <= 1'b1;
            end
            else if (status.mm_done)
            begin
                issued_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= S_LOAD;
                    end
                end
                S_LOAD:
                begin
                    pass_reg  <= 1'b0;
                    bit_reg   <= BW'(mpde_pkg::DIGIT_W - 1);
                    state_reg <= status.first ? S_BASE : S_SQUARE;
                end
                S_BASE:
                begin
                    if (status.mm_done)
                    begin
                        state_reg <= S_SQUARE;
                    end
                end
                S_SQUARE:
                begin
                    if (status.mm_done)
                    begin
                        if (cur_bit)
                        begin
                            state_reg <= S_MULX;
                        end
                        else if (bits_done)
                        begin
                            state_reg <= pass_reg ? S_FINAL : S_SAVE;
                        end
                        else
                        begin
                            bit_reg <= bit_reg - BW'(1);
                        end
                    end
                end
                S_MULX:
                begin
                    if (status.mm_done)
                    begin
                        if (bits_done)
                        begin
                            state_reg <= pass_reg ? S_FINAL : S_SAVE;
                        end
                        else
                        begin
                            bit_reg   <= bit_reg - BW'(1);
                            state_reg <= S_SQUARE;
                        end
                    end
                end
                S_SAVE:
                begin
                    pass_reg  <= 1'b1;
                    bit_reg   <= BW'(mpde_pkg::DIGIT_W - 1);
                    state_reg <= S_SQUARE;
                end
                S_FINAL:
                begin
                    if (status.mm_done)
                    begin
                        state_reg <= status.last ? S_EMIT : S_IDLE;
                    end
                end
                S_EMIT:
                begin
                    if (!status.out_full)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// File: rtl/modular_power_decimal_exponent.sv
// Modular power with a decimal exponent: each input word carries one exponent
// digit, most significant first; the word flagged first also carries the base,
// which is reduced and restarts the running result at one, and the word flagged
// last returns the result on the output channel. Every digit d turns the running
// result r into r^10 * a^d mod the configured modulus (reset 1337, zero means
// wrap at 2^MOD_WIDTH). One word is worked on at a time. All the work runs
// through a single modular multiplier whose remainder unit takes four dividend
// bits per cycle and stops after its first step with a zero modulus. A digit
// needs 11 + popcount(d) multiplications, one more on a first word. A waiting
// result does not stop the next word from being taken until another result is
// due; the block then holds until the output is free. The modulus is written
// through cfg_we and cfg_wdata while the block is idle; the user must keep to
// this, as the block itself does not enforce it.
module modular_power_decimal_exponent #(
    parameter int MOD_WIDTH = mpde_pkg::MOD_WIDTH_DEFAULT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    mpde_in_if.sink                    in_ch,
    mpde_out_if.source                 out_ch,
    input  logic                       cfg_we,
    input  logic [mpde_pkg::CFG_W-1:0] cfg_wdata
);

    mpde_pkg::ctrl_cmd_t    cmd;
    mpde_pkg::ctrl_status_t status;
    logic                   in_ready;

    assign in_ch.ready = in_ready;

    // sequencer
    mpde_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ready),
        .cmd      (cmd),
        .status   (status)
    );

    // registers and shared modular multiplier
    mpde_datapath #(
        .W (MOD_WIDTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .base_value   (in_ch.base_value),
        .exp_digit    (in_ch.exp_digit),
        .first_digit  (in_ch.first_digit),
        .last_digit   (in_ch.last_digit),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .out_ready    (out_ch.ready),
        .out_valid    (out_ch.valid),
        .power_result (out_ch.power_result),
        .cmd          (cmd),
        .status       (status)
    );

endmodule

// File: rtl/mpde_checker.sv
module mpde_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [mpde_pkg::RESULT_W-1:0] power_result
);

    // an accepted word keeps the input closed at the start of its work
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready ##1 !in_ready)
    else $error("input taken again too soon after a word");

    // a new result only appears at the end of a word's work
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared while the block was idle");

    // a stalled result word holds its value
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(power_result))
    else $error("stalled result word changed or dropped");

endmodule

bind modular_power_decimal_exponent mpde_checker u_mpde_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .power_result (out_ch.power_result)
);

// File: tb/mpde_power_monitor.sv
module mpde_power_monitor (
    input  logic                       clk,
    input  logic                       rst_n,
    mpde_in_if                         in_ch,
    mpde_out_if                        out_ch,
    input  logic                       cfg_we,
    input  logic [mpde_pkg::CFG_W-1:0] cfg_wdata,
    output int                         error_count,
    output int                         pending_results
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          MW        = mpde_pkg::MOD_WIDTH_DEFAULT;
    localparam logic [63:0] WRAP_MASK = (64'd1 << MW) - 64'd1;

    // predicted block state
    logic [MW-1:0]                 modulus_q = MW'(mpde_pkg::MODULUS_RESET);
    logic [MW-1:0]                 power_q   = MW'(1);
    logic [MW-1:0]                 base_q    = '0;
    logic [mpde_pkg::RESULT_W-1:0] expected_powers[$];
    int                            mismatches = 0;

    // reduction by the modulus, a zero modulus wraps at the register width
    function automatic logic [63:0] fold_mod(input logic [63:0] v);
        if (modulus_q == '0)
            return v & WRAP_MASK;
        return v % 64'(modulus_q);
    endfunction

    function automatic logic [63:0] mul_mod(input logic [63:0] x, input logic [63:0] y);
        return fold_mod((x & WRAP_MASK) * (y & WRAP_MASK));
    endfunction

    // x to a four-bit power, square-and-multiply from the top bit
    function automatic logic [63:0] pow_nibble(input logic [63:0] x,
                                               input logic [mpde_pkg::DIGIT_W-1:0] e);
        logic [63:0] acc;
        acc = 64'd1;
        for (int b = mpde_pkg::DIGIT_W - 1; b >= 0; b--)
        begin
            acc = mul_mod(acc, acc);
            if (e[b])
                acc = mul_mod(acc, x);
        end
        return acc;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        logic [63:0]                   r10;
        logic [mpde_pkg::RESULT_W-1:0] want;
        if (!rst_n)
        begin
            modulus_q = MW'(mpde_pkg::MODULUS_RESET);
            power_q   = MW'(1);
            base_q    = '0;
            expected_powers.delete();
        end
        else
        begin
            // compare the result word with the oldest prediction
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_powers.size() == 0)
                begin
                    $error("power_result: expected none, actual %0d", out_ch.power_result);
                    mismatches++;
                end
                else
                begin
                    want = expected_powers.pop_front();
                    if (out_ch.power_result !== want)
                    begin
                        $error("power_result: expected %0d, actual %0d",
                               want, out_ch.power_result);
                        mismatches++;
                    end
                end
            end

            // one digit of the exponent: r = r^10 * a^d
            if (in_ch.valid && in_ch.ready)
            begin
                if (in_ch.first_digit)
                begin
                    base_q  = MW'(fold_mod(64'(in_ch.base_value)));
                    power_q = MW'(1);
                end
                r10     = pow_nibble(64'(power_q), mpde_pkg::POW_TEN);
                power_q = MW'(mul_mod(r10, pow_nibble(64'(base_q), in_ch.exp_digit)));
                if (in_ch.last_digit)
                    expected_powers.push_back(mpde_pkg::RESULT_W'(power_q));
            end

            // modulus register
            if (cfg_we)
                modulus_q = MW'(cfg_wdata);
        end
        error_count     <= mismatches;
        pending_results <= expected_powers.size();
    end

endmodule

// File: tb/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HALF_PERIOD    = 4;
    localparam int RESET_CYCLES   = 11;
    localparam int DRAIN_CYCLES   = 256;
    localparam int HOLD_CYCLES    = 1500;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int NUM_PHASES     = 8;
    localparam int PHASE_WORDS    = 170;
    localparam int PCT_ONE_SIDE   = 47;
    localparam int PCT_BOTH       = 28;

    typedef enum logic [1:0] {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idling_t;

    logic                       clk       = 1'b0;
    logic                       rst_n     = 1'b0;
    logic                       cfg_we    = 1'b0;
    logic [mpde_pkg::CFG_W-1:0] cfg_wdata = '0;

    int src_idle_pct    = 0;
    int snk_stall_pct   = 0;
    int holds_requested = 0;
    int holds_served    = 0;
    int hold_left       = 0;
    int words_sent      = 0;
    int error_count;
    int pending_results;

    logic [mpde_pkg::CFG_W-1:0] phase_modulus[NUM_PHASES];
    idling_t                    phase_idling[NUM_PHASES];

    mpde_in_if  in_ch ();
    mpde_out_if out_ch ();

    modular_power_decimal_exponent dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    mpde_power_monitor power_mon (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_ch           (in_ch),
        .out_ch          (out_ch),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .error_count     (error_count),
        .pending_results (pending_results)
    );

    // clock
    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    // result receiver, random stalls plus a requested long hold-off
    always @(posedge clk)
    begin
        if (holds_served != holds_requested)
        begin
            holds_served++;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ch.ready <= 1'b0;
        end
        else
            out_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
    end

    // watchdog on cycles with no word moving and no modulus write
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we)
                quiet = 0;
            else
                quiet++;
        end
        $display("tb_top NOT OK");
        $finish;
    end

    function automatic logic [mpde_pkg::BASE_W-1:0] pick_base();
        case ($urandom_range(5))
            0: return {mpde_pkg::BASE_W{1'b1}};
            1: return mpde_pkg::BASE_W'($urandom_range(16));
            2: return mpde_pkg::BASE_W'($urandom_range(65535, 1));
            3: return mpde_pkg::BASE_W'($urandom_range(40, 1) * 1337);
            default: return mpde_pkg::BASE_W'($urandom);
        endcase
    endfunction

    // mostly decimal digits, now and then one above nine
    function automatic logic [mpde_pkg::DIGIT_W-1:0] pick_digit();
        if ($urandom_range(11) == 0)
            return mpde_pkg::DIGIT_W'($urandom_range(15, 10));
        return mpde_pkg::DIGIT_W'($urandom_range(9));
    endfunction

    task automatic set_idling(input idling_t mode);
        src_idle_pct = (mode == IDLE_SENDER) ? PCT_ONE_SIDE :
                       (mode == IDLE_BOTH)   ? PCT_BOTH : 0;
        snk_stall_pct <= (mode == IDLE_RECEIVER) ? PCT_ONE_SIDE :
                         (mode == IDLE_BOTH)     ? PCT_BOTH : 0;
    endtask

    // offer one digit word and hold it until taken
    task automatic send_word(input logic [mpde_pkg::BASE_W-1:0] base,
                             input logic [mpde_pkg::DIGIT_W-1:0] digit,
                             input logic first, input logic last);
        while ($urandom_range(99) < src_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.base_value  <= base;
        in_ch.exp_digit   <= digit;
        in_ch.first_digit <= first;
        in_ch.last_digit  <= last;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        words_sent++;
    endtask

    // a well-formed exponent of the given number of digits
    task automatic send_exponent(input logic [mpde_pkg::BASE_W-1:0] base, input int length);
        for (int i = 0; i < length; i++)
            send_word((i == 0) ? base : mpde_pkg::BASE_W'($urandom), pick_digit(),
                      i == 0, i == length - 1);
    endtask

    // stop offering, let every result come back and the block go quiet
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_modulus(input logic [mpde_pkg::CFG_W-1:0] value);
        cfg_wdata <= value;
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial
    begin
        int stop_at;
        int pause_at;
        bit paused;

        in_ch.valid       = 1'b0;
        in_ch.base_value  = '0;
        in_ch.exp_digit   = '0;
        in_ch.first_digit = 1'b0;
        in_ch.last_digit  = 1'b0;

        phase_modulus = '{16'd1337, 16'hFFFF, 16'd2, 16'd0, 16'd1,
                          mpde_pkg::CFG_W'($urandom_range(65534, 3)),
                          mpde_pkg::CFG_W'($urandom_range(65534, 3)),
                          mpde_pkg::CFG_W'($urandom_range(65534, 3))};
        phase_idling  = '{IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH,
                          IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH};

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_idling(IDLE_NONE);

        // digits before any first flag run on the reset state
        send_word(31'd12345, 4'd7, 1'b0, 1'b0);
        send_word(31'd999, 4'd3, 1'b0, 1'b1);
        // single-digit exponents: extreme base, zero power, zero base, high digits
        send_word({mpde_pkg::BASE_W{1'b1}}, 4'd9, 1'b1, 1'b1);
        send_word(31'd1, 4'd0, 1'b1, 1'b1);
        send_word(31'd1337, 4'd0, 1'b1, 1'b1);
        send_word(31'd6685, 4'd4, 1'b1, 1'b1);
        send_word(31'd0, 4'd0, 1'b1, 1'b1);
        send_word(31'd0, 4'd15, 1'b1, 1'b1);
        send_word(31'd2, 4'd15, 1'b1, 1'b1);
        send_word(31'd3, 4'd10, 1'b1, 1'b1);
        // three-digit exponent, then digits extending it past its last flag
        send_word(31'd123456, 4'd1, 1'b1, 1'b0);
        send_word(31'd0, 4'd2, 1'b0, 1'b0);
        send_word(31'd0, 4'd9, 1'b0, 1'b1);
        send_word(31'd77, 4'd5, 1'b0, 1'b1);
        send_word(31'd0, 4'd0, 1'b0, 1'b0);
        send_word(31'd0, 4'd3, 1'b0, 1'b1);
        // modulus changed in the middle of an exponent, wrap mode included
        send_word(31'd54321, 4'd8, 1'b1, 1'b0);
        wait_drained();
        write_modulus(16'd1000);
        send_word(31'd0, 4'd6, 1'b0, 1'b0);
        wait_drained();
        write_modulus(16'd0);
        send_word(31'd0, 4'd9, 1'b0, 1'b1);
        send_word({mpde_pkg::BASE_W{1'b1}}, 4'd7, 1'b1, 1'b1);
        wait_drained();
        write_modulus(16'd1);
        send_word(31'd5, 4'd3, 1'b1, 1'b1);
        wait_drained();
        write_modulus(16'hFFFF);
        send_word({mpde_pkg::BASE_W{1'b1}}, 4'd9, 1'b1, 1'b0);
        send_word(31'd0, 4'd15, 1'b0, 1'b1);
        wait_drained();
        write_modulus(16'd2);
        send_word(31'd3, 4'd7, 1'b1, 1'b1);

        // random phases, one modulus and one idling pattern each
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            wait_drained();
            write_modulus(phase_modulus[p]);
            set_idling(phase_idling[p]);
            if (p == 0)
            begin
                // receiver holds off while short exponents keep coming
                holds_requested <= holds_requested + 1;
                repeat (12) send_word(pick_base(), pick_digit(), 1'b1, 1'b1);
            end
            stop_at  = words_sent + PHASE_WORDS;
            pause_at = words_sent + PHASE_WORDS / 2;
            paused   = 1'b0;
            while (words_sent < stop_at)
            begin
                if (!paused && words_sent >= pause_at)
                begin
                    wait_drained();
                    paused = 1'b1;
                end
                if ($urandom_range(9) == 0)
                    send_word(mpde_pkg::BASE_W'($urandom), mpde_pkg::DIGIT_W'($urandom),
                              1'($urandom), 1'($urandom));
                else
                    send_exponent(pick_base(), ($urandom_range(7) == 0) ?
                                  $urandom_range(12, 5) : $urandom_range(4, 1));
            end
        end

        wait_drained();
        if (error_count == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
